>>> hdl/dro_pkg.sv
// Package for the dead-reckoning odometry integrator.
// Holds fixed-point constants, the sequencer and term codes, and the
// CORDIC arctangent table. No dependencies.
package dro_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);

  // Rotator datapath width, Q.16 velocity with CORDIC growth headroom
  localparam int XW = 34;
  // Multiplier operands and product
  localparam int MA_W = XW;
  localparam int MB_W = 31;
  localparam int MP_W = MA_W + MB_W;

  localparam logic [MB_W-1:0] GAIN_Q30 = MB_W'(652032874);

  // 0.3 s limit on the interval
  localparam logic signed [20:0] MAX_INTERVAL_US = 21'sd300000;
  localparam logic signed [20:0] MIN_INTERVAL_US = -21'sd300000;

  // All rounded divisions reduce to floor(n / 1e6) with n < 2^42. A reciprocal
  // multiply on n / 2^10 gives q or q - 1; a multiply-back settles which.
  localparam int DIV_Q_BITS  = 22;
  localparam int DIV_N_BITS  = 42;
  localparam int DIV_N_DROP  = 10;
  localparam int RECIP_SHIFT = 49;
  localparam int QEST_LSB    = RECIP_SHIFT - DIV_N_DROP;
  // floor(2^49 / 1e6)
  localparam logic [MB_W-1:0] RECIP_1E6 = MB_W'(562949953);
  localparam logic [MB_W-1:0] DIVISOR_B = MB_W'(1000000);
  localparam logic [DIV_N_BITS-1:0] DIVISOR_N = DIV_N_BITS'(1000000);
  localparam logic [MP_W-1:0] BODY_BIAS  = MP_W'(500000);
  localparam logic [MP_W-1:0] WORLD_BIAS = MP_W'(128000000);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0_0000_0000_0001,
    S_GAIN_X   = 13'b0_0000_0000_0010,
    S_GAIN_Y   = 13'b0_0000_0000_0100,
    S_ROT_INIT = 13'b0_0000_0000_1000,
    S_ROT      = 13'b0_0000_0001_0000,
    S_VEL      = 13'b0_0000_0010_0000,
    S_MUL      = 13'b0_0000_0100_0000,
    S_PREP     = 13'b0_0000_1000_0000,
    S_DIV      = 13'b0_0001_0000_0000,
    S_QEST     = 13'b0_0010_0000_0000,
    S_FIX      = 13'b0_0100_0000_0000,
    S_ACC      = 13'b0_1000_0000_0000,
    S_DONE     = 13'b1_0000_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    TERM_BODY_X,
    TERM_BODY_Y,
    TERM_WORLD_X,
    TERM_WORLD_Y,
    TERM_TURN
  } term_t;

  // atan(2^-i) in 2^32 units per turn, rounded to ANGLE_BITS
  function automatic logic [ANGLE_BITS-1:0] atan_step(input logic [4:0] i);
    logic [31:0] raw;
    logic [32:0] rnd;
    begin
      case (i)
        5'd0:    raw = 32'd536870912;
        5'd1:    raw = 32'd316933406;
        5'd2:    raw = 32'd167458907;
        5'd3:    raw = 32'd85004756;
        5'd4:    raw = 32'd42667331;
        5'd5:    raw = 32'd21354465;
        5'd6:    raw = 32'd10679838;
        5'd7:    raw = 32'd5340245;
        5'd8:    raw = 32'd2670163;
        5'd9:    raw = 32'd1335087;
        5'd10:   raw = 32'd667544;
        5'd11:   raw = 32'd333772;
        5'd12:   raw = 32'd166886;
        5'd13:   raw = 32'd83443;
        5'd14:   raw = 32'd41722;
        5'd15:   raw = 32'd20861;
        5'd16:   raw = 32'd10430;
        5'd17:   raw = 32'd5215;
        5'd18:   raw = 32'd2608;
        5'd19:   raw = 32'd1304;
        5'd20:   raw = 32'd652;
        5'd21:   raw = 32'd326;
        5'd22:   raw = 32'd163;
        5'd23:   raw = 32'd81;
        default: raw = 32'd0;
      endcase
      rnd = {1'b0, raw} + (33'd1 << (31 - ANGLE_BITS));
      return rnd[31:32-ANGLE_BITS];
    end
  endfunction

  // 16-bit heading to ANGLE_BITS binary angle
  function automatic logic [ANGLE_BITS-1:0] head_to_angle(input logic [15:0] hd);
    logic [ANGLE_BITS+15:0] ext;
    begin
      ext = {hd, {ANGLE_BITS{1'b0}}};
      return ext[ANGLE_BITS+15:16];
    end
  endfunction

endpackage

>>> hdl/dead_reckoning_odometry_integrator.sv
// Top level of the planar dead-reckoning odometry integrator.
// Uses dro_pkg for constants, sequencer codes and the arctangent table.

// Each transfer on the input channel is a velocity sample or a clear request and
// yields exactly one result transfer showing the state after the item. A clear,
// or a sample whose interval exceeds 0.3 s in magnitude, goes from idle straight
// to the result state. An applied sample is worked as follows: one
// shared 34x31 multiplier scales the velocity for the CORDIC, the rotator then
// runs one iteration per cycle, and each of the five products (two body, two
// world, one turn) goes through the same multiplier, followed by a division by
// 10^6 done as a reciprocal multiply and a multiply-back correction on that
// multiplier. The input is not ready while an item is in work; the result sits
// in its own output register, so a new item is taken while an earlier result waits.
module dead_reckoning_odometry_integrator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic signed [23:0] vel_x,
  input  logic signed [23:0] vel_y,
  input  logic signed [23:0] turn_rate,
  input  logic signed [20:0] interval_us,
  input  logic        [15:0] set_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               accepted,
  output logic signed [23:0] world_vel_x,
  output logic signed [23:0] world_vel_y,
  output logic signed [47:0] body_dist_x,
  output logic signed [47:0] body_dist_y,
  output logic signed [47:0] world_dist_x,
  output logic signed [47:0] world_dist_y,
  output logic        [15:0] turned_angle,
  output logic        [15:0] heading
);
  import dro_pkg::*;

  state_t state;
  term_t  term;

  // architectural state
  logic [15:0] heading_reg;
  logic [15:0] turned_reg;
  logic [47:0] body_acc_x, body_acc_y;
  logic [47:0] world_acc_x, world_acc_y;
  logic [23:0] wvel_x, wvel_y;
  logic        applied;

  // sample and datapath registers
  logic signed [23:0] smp_vx, smp_vy, smp_turn;
  logic signed [20:0] smp_dur;
  logic signed [XW-1:0] x, y;
  logic signed [ANGLE_BITS:0] z;
  logic [ITER_W-1:0] iter;
  logic signed [MP_W-1:0] prod;
  logic [DIV_N_BITS-1:0] nd;
  logic [DIV_Q_BITS-1:0] nq;
  logic div_neg;

  // combinational
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic [MP_W-1:0] gain_sum;
  logic [ANGLE_BITS-1:0] ang, ang_f;
  logic fold;
  logic signed [XW-1:0] y_scaled;
  logic signed [XW-1:0] dx, dy;
  logic [ANGLE_BITS:0] t_ext;
  logic [XW-1:0] rx_sum, ry_sum;
  logic [23:0] rx_sat, ry_sat;
  logic term_body;
  logic [MP_W-1:0] bias, n_pre;
  logic [DIV_N_BITS-1:0] n_div;
  logic [DIV_N_BITS-1:0] rem_est;
  logic rem_ge;
  logic [47:0] q_mag, q_signed;
  logic reject;

  function automatic logic [23:0] sat24(input logic [XW-1:0] sum);
    logic signed [XW-9:0] r;
    begin
      r = $signed(sum[XW-1:8]);
      if (r > (XW - 8)'(8388607)) begin
        return 24'h7FFFFF;
      end else if (r < -(XW - 8)'(8388608)) begin
        return 24'h800000;
      end else begin
        return r[23:0];
      end
    end
  endfunction

  assign in_ready = (state == S_IDLE);
  assign reject   = (interval_us > MAX_INTERVAL_US) || (interval_us < MIN_INTERVAL_US);

  // shared multiplier operand select
  always_comb begin
    mul_a = MA_W'(smp_vx);
    mul_b = $signed(GAIN_Q30);
    unique case (state)
      S_GAIN_Y: mul_a = MA_W'(smp_vy);
      S_MUL: begin
        mul_b = MB_W'(smp_dur);
        case (term)
          TERM_BODY_X:  mul_a = MA_W'(smp_vx);
          TERM_BODY_Y:  mul_a = MA_W'(smp_vy);
          TERM_WORLD_X: mul_a = x;
          TERM_WORLD_Y: mul_a = y;
          default:      mul_a = MA_W'(smp_turn);
        endcase
      end
      S_DIV: begin
        mul_a = MA_W'(nd[DIV_N_BITS-1:DIV_N_DROP]);
        mul_b = $signed(RECIP_1E6);
      end
      S_QEST: begin
        mul_a = MA_W'(prod[QEST_LSB +: DIV_Q_BITS]);
        mul_b = $signed(DIVISOR_B);
      end
      default: mul_a = MA_W'(smp_vx);
    endcase
  end

  // gain scaling: floor((v * gain + 2^21) / 2^22)
  assign gain_sum = prod + (MP_W'(1) << 21);
  assign y_scaled = $signed(gain_sum[22 +: XW]);

  assign ang   = ANGLE_BITS'(0) - head_to_angle(heading_reg);
  assign fold  = ang[ANGLE_BITS-1] ^ ang[ANGLE_BITS-2];
  assign ang_f = {ang[ANGLE_BITS-1] ^ fold, ang[ANGLE_BITS-2:0]};

  assign dx    = y >>> iter;
  assign dy    = x >>> iter;
  assign t_ext = {1'b0, atan_step(5'(iter))};

  // round half away from zero to Q.8
  assign rx_sum = x + (x[XW-1] ? XW'(127) : XW'(128));
  assign ry_sum = y + (y[XW-1] ? XW'(127) : XW'(128));
  assign rx_sat = sat24(rx_sum);
  assign ry_sat = sat24(ry_sum);

  // |p| + bias in one add, then floor division by 1e6 (world and turn terms drop 8 bits first)
  assign term_body = (term == TERM_BODY_X) || (term == TERM_BODY_Y);
  assign bias      = term_body ? BODY_BIAS : WORLD_BIAS;
  assign n_pre     = prod[MP_W-1] ? (bias - prod) : (prod + bias);
  assign n_div     = term_body ? n_pre[DIV_N_BITS-1:0] : n_pre[DIV_N_BITS+7:8];

  // remainder of the quotient estimate, below 2e6
  assign rem_est = nd - prod[DIV_N_BITS-1:0];
  assign rem_ge  = (rem_est >= DIVISOR_N);

  assign q_mag    = 48'(nq);
  assign q_signed = div_neg ? (48'd0 - q_mag) : q_mag;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (rst) begin
      state       <= S_IDLE;
      term        <= TERM_BODY_X;
      out_valid   <= 1'b0;
      heading_reg <= '0;
      turned_reg  <= '0;
      body_acc_x  <= '0;
      body_acc_y  <= '0;
      world_acc_x <= '0;
      world_acc_y <= '0;
      wvel_x      <= '0;
      wvel_y      <= '0;
      applied     <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            smp_vx   <= vel_x;
            smp_vy   <= vel_y;
            smp_turn <= turn_rate;
            smp_dur  <= interval_us;
            if (req_type) begin
              applied     <= 1'b1;
              heading_reg <= set_heading;
              turned_reg  <= '0;
              body_acc_x  <= '0;
              body_acc_y  <= '0;
              world_acc_x <= '0;
              world_acc_y <= '0;
              state       <= S_DONE;
            end else if (reject) begin
              applied <= 1'b0;
              state   <= S_DONE;
            end else begin
              applied <= 1'b1;
              state   <= S_GAIN_X;
            end
          end
        end
        S_GAIN_X: state <= S_GAIN_Y;
        S_GAIN_Y: begin
          x     <= y_scaled;
          state <= S_ROT_INIT;
        end
        S_ROT_INIT: begin
          x     <= fold ? -x : x;
          y     <= fold ? -y_scaled : y_scaled;
          z     <= {ang_f[ANGLE_BITS-1], ang_f};
          iter  <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (!z[ANGLE_BITS]) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - $signed(t_ext);
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + $signed(t_ext);
          end
          iter <= iter + 1'b1;
          if (iter == ITER_W'(CORDIC_STEPS - 1)) begin
            state <= S_VEL;
          end
        end
        S_VEL: begin
          wvel_x <= rx_sat;
          wvel_y <= ry_sat;
          term   <= TERM_BODY_X;
          state  <= S_MUL;
        end
        S_MUL: state <= S_PREP;
        S_PREP: begin
          nd      <= n_div;
          div_neg <= prod[MP_W-1];
          state   <= S_DIV;
        end
        S_DIV: state <= S_QEST;
        S_QEST: begin
          nq    <= prod[QEST_LSB +: DIV_Q_BITS];
          state <= S_FIX;
        end
        S_FIX: begin
          nq    <= nq + DIV_Q_BITS'(rem_ge);
          state <= S_ACC;
        end
        S_ACC: begin
          case (term)
            TERM_BODY_X: begin
              body_acc_x <= body_acc_x + q_signed;
              term       <= TERM_BODY_Y;
              state      <= S_MUL;
            end
            TERM_BODY_Y: begin
              body_acc_y <= body_acc_y + q_signed;
              term       <= TERM_WORLD_X;
              state      <= S_MUL;
            end
            TERM_WORLD_X: begin
              world_acc_x <= world_acc_x + q_signed;
              term        <= TERM_WORLD_Y;
              state       <= S_MUL;
            end
            TERM_WORLD_Y: begin
              world_acc_y <= world_acc_y + q_signed;
              term        <= TERM_TURN;
              state       <= S_MUL;
            end
            default: begin
              heading_reg <= heading_reg + q_signed[15:0];
              turned_reg  <= turned_reg + q_signed[15:0];
              state       <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            accepted     <= applied;
            world_vel_x  <= wvel_x;
            world_vel_y  <= wvel_y;
            body_dist_x  <= body_acc_x;
            body_dist_y  <= body_acc_y;
            world_dist_x <= world_acc_x;
            world_dist_y <= world_acc_y;
            turned_angle <= turned_reg;
            heading      <= heading_reg;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/sv/dead_reckoning_odometry_integrator_test.sv
// Self-checking testbench for dead_reckoning_odometry_integrator.
// Runs a directed table, then random samples and clears with random idling on both channels,
// and checks every result against a cycle-free odometry predictor or, for fixed table rows, the table. Uses dro_pkg.
module dead_reckoning_odometry_integrator_test;

  localparam bit REQ_SAMPLE = 1'b0;
  localparam bit REQ_CLEAR  = 1'b1;

  localparam int     RANDOM_ITEMS  = 1300;
  localparam int     CALM_ITEMS    = 150;
  localparam int     DRAIN_CYCLES  = 200;
  localparam int     LIMIT_CYCLES  = 1000000;
  localparam longint DUR_LIMIT_US  = 300000;
  localparam longint GAIN_Q30      = 652032874;

  localparam logic signed [23:0] VMAX = 24'sh7FFFFF;
  localparam logic signed [23:0] VMIN = 24'sh800000;

  localparam longint unsigned ARCTAN_TURN32 [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic               req_type;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] turn_rate;
    logic signed [20:0] interval_us;
    logic        [15:0] set_heading;
  } odo_item_t;

  typedef struct packed {
    logic               accepted;
    logic signed [23:0] world_vel_x;
    logic signed [23:0] world_vel_y;
    logic signed [47:0] body_dist_x;
    logic signed [47:0] body_dist_y;
    logic signed [47:0] world_dist_x;
    logic signed [47:0] world_dist_y;
    logic        [15:0] turned_angle;
    logic        [15:0] heading;
  } odo_result_t;

  typedef struct packed {
    odo_item_t   item;
    logic        fixed;
    odo_result_t want;
  } plan_row_t;

  localparam odo_result_t ZERO_APPLIED = '{accepted: 1'b1, default: '0};
  localparam odo_result_t ZERO_REJECTED = '0;

  localparam plan_row_t DIRECTED [24] = '{
    '{'{REQ_SAMPLE, 24'sd0, 24'sd0, 24'sd0, 21'sd0, 16'h0000}, 1'b1, ZERO_APPLIED},
    '{'{REQ_SAMPLE, VMAX, VMIN, VMAX, 21'sd300001, 16'h0000}, 1'b1, ZERO_REJECTED},
    '{'{REQ_SAMPLE, VMIN, VMAX, VMIN, -21'sd300001, 16'hFFFF}, 1'b1, ZERO_REJECTED},
    '{'{REQ_SAMPLE, VMAX, VMAX, VMAX, 21'sd1048575, 16'h0000}, 1'b1, ZERO_REJECTED},
    '{'{REQ_SAMPLE, VMIN, VMIN, VMIN, 21'sh100000, 16'h0000}, 1'b1, ZERO_REJECTED},
    '{'{REQ_CLEAR, VMAX, VMIN, VMAX, 21'sd0, 16'hFFFF}, 1'b1,
      '{accepted: 1'b1, heading: 16'hFFFF, default: '0}},
    '{'{REQ_SAMPLE, 24'sd256, 24'sd0, 24'sd0, 21'sd300000, 16'h0000}, 1'b0, '0},
    '{'{REQ_SAMPLE, VMAX, VMAX, VMAX, 21'sd300000, 16'h0000}, 1'b0, '0},
    '{'{REQ_SAMPLE, VMIN, VMIN, VMIN, -21'sd300000, 16'h0000}, 1'b0, '0},
    '{'{REQ_CLEAR, -24'sd1, -24'sd1, -24'sd1, -21'sd1, 16'h4000}, 1'b0, '0},
    '{'{REQ_SAMPLE, VMAX, 24'sd0, 24'sd0, 21'sd1, 16'h0000}, 1'b0, '0},
    '{'{REQ_CLEAR, 24'sd0, 24'sd0, 24'sd0, 21'sd0, 16'h8000}, 1'b0, '0},
    '{'{REQ_SAMPLE, VMIN, VMAX, 24'sd0, -21'sd1, 16'h0000}, 1'b0, '0},
    '{'{REQ_CLEAR, 24'sd0, 24'sd0, 24'sd0, 21'sd0, 16'hC000}, 1'b0, '0},
    '{'{REQ_SAMPLE, VMAX, VMIN, 24'sd1, 21'sd299999, 16'h0000}, 1'b0, '0},
    '{'{REQ_CLEAR, 24'sd0, 24'sd0, 24'sd0, 21'sd0, 16'h2000}, 1'b0, '0},
    '{'{REQ_SAMPLE, VMAX, VMAX, 24'sd0, 21'sd1000, 16'h0000}, 1'b0, '0},
    '{'{REQ_CLEAR, 24'sd0, 24'sd0, 24'sd0, 21'sd0, 16'hE000}, 1'b0, '0},
    '{'{REQ_SAMPLE, VMIN, VMIN, 24'sd0, 21'sd1000, 16'h0000}, 1'b0, '0},
    '{'{REQ_SAMPLE, -24'sd1, 24'sd1, -24'sd1, 21'sd3, 16'h0000}, 1'b0, '0},
    '{'{REQ_SAMPLE, 24'sd5, -24'sd5, 24'sd1280, 21'sd100000, 16'h0000}, 1'b0, '0},
    '{'{REQ_SAMPLE, 24'sh123456, -24'sh0ABCDE, 24'sh400000, -21'sd300002, 16'h0000},
      1'b0, '0},
    '{'{REQ_CLEAR, 24'sd0, 24'sd0, 24'sd0, 21'sd0, 16'h0000}, 1'b0, '0},
    '{'{REQ_SAMPLE, 24'sd100, 24'sd200, VMIN, 21'sd300000, 16'h0000}, 1'b0, '0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               req_type = 1'b0;
  logic signed [23:0] vel_x = '0;
  logic signed [23:0] vel_y = '0;
  logic signed [23:0] turn_rate = '0;
  logic signed [20:0] interval_us = '0;
  logic        [15:0] set_heading = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               accepted;
  logic signed [23:0] world_vel_x;
  logic signed [23:0] world_vel_y;
  logic signed [47:0] body_dist_x;
  logic signed [47:0] body_dist_y;
  logic signed [47:0] world_dist_x;
  logic signed [47:0] world_dist_y;
  logic        [15:0] turned_angle;
  logic        [15:0] heading;

  dead_reckoning_odometry_integrator dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted integrator state
  logic        [15:0] head_now = '0;
  logic        [15:0] turned_now = '0;
  logic        [47:0] body_x = '0;
  logic        [47:0] body_y = '0;
  logic        [47:0] world_x = '0;
  logic        [47:0] world_y = '0;
  logic signed [23:0] wvel_x = '0;
  logic signed [23:0] wvel_y = '0;

  odo_result_t pending_results[$];
  int          mismatches = 0;
  int          result_idx = 0;
  bit          calm = 1'b0;

  function automatic longint round_div(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [23:0] clamp24(input longint v);
    if (v > 8388607) return VMAX;
    if (v < -8388608) return VMIN;
    return 24'(v);
  endfunction

  // rotate by minus the heading, result in Q.16
  function automatic void rotate_to_world(input longint vx, input longint vy,
                                          input logic [15:0] hd,
                                          output longint wx, output longint wy);
    longint unsigned amask;
    longint unsigned quarter;
    longint unsigned ang;
    longint x;
    longint y;
    longint z;
    longint t;
    longint dx;
    longint dy;
    amask = (64'd1 << dro_pkg::ANGLE_BITS) - 64'd1;
    quarter = 64'd1 << (dro_pkg::ANGLE_BITS - 2);
    if (dro_pkg::ANGLE_BITS >= 16)
      ang = longint'(hd) << (dro_pkg::ANGLE_BITS - 16);
    else
      ang = longint'(hd) >> (16 - dro_pkg::ANGLE_BITS);
    ang = (64'd0 - ang) & amask;
    x = (vx * GAIN_Q30 + (longint'(1) <<< 21)) >>> 22;
    y = (vy * GAIN_Q30 + (longint'(1) <<< 21)) >>> 22;
    if (ang >= quarter && ang < 3 * quarter) begin
      x = -x;
      y = -y;
      ang = (ang - 2 * quarter) & amask;
    end
    if (ang >= (64'd1 << (dro_pkg::ANGLE_BITS - 1)))
      z = longint'(ang) - (longint'(1) <<< dro_pkg::ANGLE_BITS);
    else
      z = longint'(ang);
    for (int i = 0; i < dro_pkg::CORDIC_STEPS && i < 24; i++) begin
      t = longint'((ARCTAN_TURN32[i] + (64'd1 << (31 - dro_pkg::ANGLE_BITS)))
                   >> (32 - dro_pkg::ANGLE_BITS));
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - t;
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + t;
      end
    end
    wx = x;
    wy = y;
  endfunction

  function automatic odo_result_t advance_odometry(input odo_item_t it);
    longint      vx;
    longint      vy;
    longint      tr;
    longint      d;
    longint      wx;
    longint      wy;
    longint      da;
    odo_result_t r;
    vx = it.vel_x;
    vy = it.vel_y;
    tr = it.turn_rate;
    d = it.interval_us;
    r.accepted = 1'b1;
    if (it.req_type == REQ_CLEAR) begin
      body_x = '0;
      body_y = '0;
      world_x = '0;
      world_y = '0;
      turned_now = '0;
      head_now = it.set_heading;
    end else if (d > DUR_LIMIT_US || d < -DUR_LIMIT_US) begin
      r.accepted = 1'b0;
    end else begin
      rotate_to_world(vx, vy, head_now, wx, wy);
      wvel_x = clamp24(round_div(wx, 256));
      wvel_y = clamp24(round_div(wy, 256));
      body_x = body_x + 48'(round_div(vx * d, 1000000));
      body_y = body_y + 48'(round_div(vy * d, 1000000));
      world_x = world_x + 48'(round_div(wx * d, 256000000));
      world_y = world_y + 48'(round_div(wy * d, 256000000));
      da = round_div(tr * d, 256000000);
      head_now = head_now + 16'(da);
      turned_now = turned_now + 16'(da);
    end
    r.world_vel_x = wvel_x;
    r.world_vel_y = wvel_y;
    r.body_dist_x = body_x;
    r.body_dist_y = body_y;
    r.world_dist_x = world_x;
    r.world_dist_y = world_y;
    r.turned_angle = turned_now;
    r.heading = head_now;
    return r;
  endfunction

  function automatic logic signed [23:0] pick_rate();
    logic signed [23:0] r;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: r = VMAX;
          1: r = VMIN;
          2: r = 24'sd1;
          3: r = -24'sd1;
          default: r = 24'sd0;
        endcase
      end
      1, 2: r = 24'($urandom);
      default: r = 24'($urandom) >>> $urandom_range(1, 20);
    endcase
    return r;
  endfunction

  task automatic send_item(input odo_item_t it, input int gap, input logic fixed,
                           input odo_result_t want);
    odo_result_t pred;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_type <= it.req_type;
    vel_x <= it.vel_x;
    vel_y <= it.vel_y;
    turn_rate <= it.turn_rate;
    interval_us <= it.interval_us;
    set_heading <= it.set_heading;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pred = advance_odometry(it);
    pending_results.push_back(fixed ? want : pred);
  endtask

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d: %s expected %0d got %0d",
                 result_idx, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_watch
    odo_result_t want;
    odo_result_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{accepted, world_vel_x, world_vel_y, body_dist_x, body_dist_y,
              world_dist_x, world_dist_y, turned_angle, heading};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d with nothing pending", result_idx);
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", want.accepted, got.accepted);
        check_field("world_vel_x", want.world_vel_x, got.world_vel_x);
        check_field("world_vel_y", want.world_vel_y, got.world_vel_y);
        check_field("body_dist_x", want.body_dist_x, got.body_dist_x);
        check_field("body_dist_y", want.body_dist_y, got.body_dist_y);
        check_field("world_dist_x", want.world_dist_x, got.world_dist_x);
        check_field("world_dist_y", want.world_dist_y, got.world_dist_y);
        check_field("turned_angle", want.turned_angle, got.turned_angle);
        check_field("heading", want.heading, got.heading);
      end
      result_idx++;
    end
  end

  // result-side backpressure
  initial begin
    @(posedge clk);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin
    odo_item_t it;
    int        mag;
    int        sel;
    int        gap;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[k]) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0;
      send_item(DIRECTED[k].item, gap, DIRECTED[k].fixed, DIRECTED[k].want);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - CALM_ITEMS)
        calm = 1'b1;
      sel = $urandom_range(0, 99);
      it.req_type = (sel < 6) ? REQ_CLEAR : REQ_SAMPLE;
      it.vel_x = pick_rate();
      it.vel_y = pick_rate();
      it.turn_rate = pick_rate();
      it.set_heading = 16'($urandom);
      if (sel >= 6 && sel < 14) begin
        // duration out of range
        if ($urandom_range(0, 9) == 0) begin
          it.interval_us = 21'sh100000;
        end else begin
          mag = ($urandom_range(0, 4) == 0) ? 300001 : $urandom_range(300001, 1048575);
          it.interval_us = $urandom_range(0, 1) ? -21'(mag) : 21'(mag);
        end
      end else begin
        case ($urandom_range(0, 3))
          0: mag = $urandom_range(0, 2000);
          1: mag = ($urandom_range(0, 1) != 0) ? 300000 : $urandom_range(299000, 300000);
          default: mag = $urandom_range(0, 300000);
        endcase
        it.interval_us = $urandom_range(0, 1) ? -21'(mag) : 21'(mag);
      end
      gap = (!calm && $urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0;
      send_item(it, gap, 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
